### rtl/core/smn64_pkg.sv
package smn64_pkg;

  localparam int unsigned MAX_ROUNDS_DEF = 44;
  localparam int unsigned ROUNDS_THREE   = 42;
  localparam int unsigned ROUNDS_FOUR    = 44;
  localparam int unsigned KEY_WORDS_3    = 3;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEYLEN = 3'd4;

  localparam logic [2:0] KEYLEN_RST = 3'd4;

  // z sequences, index 0 is the first bit of the sequence
  localparam logic [0:61] Z_TWO =
    62'b10101111011100000011010010011000101000010001111110010110110011;
  localparam logic [0:61] Z_THREE =
    62'b11011011101011000110010111100000010010001010011100110100001111;

  typedef struct packed {
    logic              command;
    logic [WORD_W-1:0] left_word;
    logic [WORD_W-1:0] right_word;
  } smn64_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] left_result;
    logic [WORD_W-1:0] right_result;
  } smn64_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_RUN,
    ST_DONE
  } smn64_state_t;

  typedef struct packed {
    logic step;
    logic done;
  } smn64_kx_ctl_t;

  typedef struct packed {
    logic four;
    logic dirty;
  } smn64_kx_stat_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic apply;
    logic wr_en;
    logic decrypt;
  } smn64_dp_ctl_t;

  function automatic logic [WORD_W-1:0] round_f(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] r1;
    logic [WORD_W-1:0] r2;
    logic [WORD_W-1:0] r8;
    r1 = {x[30:0], x[31]};
    r2 = {x[29:0], x[31:30]};
    r8 = {x[23:0], x[31:24]};
    return (r1 & r8) ^ r2;
  endfunction

  function automatic logic [WORD_W-1:0] rotr3(input logic [WORD_W-1:0] x);
    return {x[2:0], x[31:3]};
  endfunction

  function automatic logic [WORD_W-1:0] rotr1(input logic [WORD_W-1:0] x);
    return {x[0], x[31:1]};
  endfunction

endpackage

### rtl/core/simon64_block_cipher_top.sv
// Channel | Valid     | Stall     | Payload
// in      | in_valid  | in_stall  | in_data  (command, left_word, right_word)
// out     | out_valid | out_stall | out_data (left_result, right_result)
// cfg     | cfg_wr_en | -         | cfg_index, cfg_wdata
//
// Each item runs R rounds (R = 44 rounds for four key words, 42 for three):
// one round per cycle through the shared round unit, fed by the round key RAM.
// The first item after reset or after any cfg write first fills the round key
// RAM with all R round keys, one key per cycle.
// Reset is synchronous, active low, with in_stall high. The output register lets
// the next item be accepted and worked on while a result is stalled on out.
module simon64_block_cipher_top #(
  parameter int unsigned MAX_ROUNDS = smn64_pkg::MAX_ROUNDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  smn64_pkg::smn64_in_t             in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output smn64_pkg::smn64_out_t            out_data,
  input  logic                             cfg_wr_en,
  input  logic [smn64_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smn64_pkg::WORD_W-1:0]     cfg_wdata
);
  import smn64_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_ROUNDS + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_ROUNDS);

  smn64_state_t   state_r;
  smn64_state_t   state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic           dec_r;
  logic           out_valid_r;
  smn64_out_t     out_data_r;
  logic           in_acc;
  logic           out_free;
  logic [CNT_W-1:0] rounds;
  logic [CNT_W-1:0] rd_cnt;
  smn64_kx_ctl_t  kx_ctl;
  smn64_kx_stat_t kx_stat;
  smn64_dp_ctl_t  dp_ctl;
  logic [WORD_W-1:0] key_w;
  smn64_out_t     dp_res;

  assign rounds   = kx_stat.four ? CNT_W'(ROUNDS_FOUR) : CNT_W'(ROUNDS_THREE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign rd_cnt   = dec_r ? (rounds - CNT_W'(1) - cnt_r) : cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) begin
          state_nxt = kx_stat.dirty ? ST_EXPAND : ST_RUN;
        end
      end
      ST_EXPAND: begin
        if (cnt_r == rounds - CNT_W'(1)) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_RUN: begin
        if (cnt_r == rounds) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    kx_ctl.step    = 1'b0;
    kx_ctl.done    = 1'b0;
    dp_ctl.load    = 1'b0;
    dp_ctl.rd_en   = 1'b0;
    dp_ctl.apply   = 1'b0;
    dp_ctl.wr_en   = 1'b0;
    dp_ctl.decrypt = dec_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = !rst_n;
        dp_ctl.load = in_valid;
      end
      ST_EXPAND: begin
        kx_ctl.step  = 1'b1;
        dp_ctl.wr_en = 1'b1;
        kx_ctl.done  = (cnt_r == rounds - CNT_W'(1));
      end
      ST_RUN: begin
        dp_ctl.rd_en = (cnt_r != rounds);
        dp_ctl.apply = (cnt_r != '0);
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dec_r <= in_data.command;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= dp_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  smn64_keyexp #(
    .CNT_W(CNT_W)
  ) u_keyexp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (kx_ctl),
    .idx       (cnt_r),
    .stat      (kx_stat),
    .key_out   (key_w)
  );

  smn64_datapath #(
    .MAX_ROUNDS(MAX_ROUNDS),
    .ADDR_W    (ADDR_W)
  ) u_datapath (
    .clk     (clk),
    .ctl     (dp_ctl),
    .in_item (in_data),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data (key_w),
    .rd_addr (rd_cnt[ADDR_W-1:0]),
    .result  (dp_res)
  );

endmodule

### rtl/core/smn64_keyexp.sv
module smn64_keyexp #(
  parameter int unsigned CNT_W = 6
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [smn64_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smn64_pkg::WORD_W-1:0]       cfg_wdata,
  input  smn64_pkg::smn64_kx_ctl_t           ctl,
  input  logic [CNT_W-1:0]                   idx,
  output smn64_pkg::smn64_kx_stat_t          stat,
  output logic [smn64_pkg::WORD_W-1:0]       key_out
);
  import smn64_pkg::*;

  logic [WORD_W-1:0] kw_r [4];
  logic [2:0]        keylen_r;
  logic              dirty_r;
  logic [WORD_W-1:0] win_r [4];
  logic              four;
  logic [CNT_W-1:0]  m;
  logic [5:0]        zi;
  logic [WORD_W-1:0] t0;
  logic [WORD_W-1:0] t1;
  logic              zb;
  logic [WORD_W-1:0] old_k;

  assign four = (keylen_r != 3'(KEY_WORDS_3));
  assign m    = four ? CNT_W'(4) : CNT_W'(KEY_WORDS_3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_r[0]  <= '0;
      kw_r[1]  <= '0;
      kw_r[2]  <= '0;
      kw_r[3]  <= '0;
      keylen_r <= KEYLEN_RST;
      dirty_r  <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        dirty_r <= 1'b1;
        unique case (cfg_index)
          CFG_KEY0:   kw_r[0]  <= cfg_wdata;
          CFG_KEY1:   kw_r[1]  <= cfg_wdata;
          CFG_KEY2:   kw_r[2]  <= cfg_wdata;
          CFG_KEY3:   kw_r[3]  <= cfg_wdata;
          CFG_KEYLEN: keylen_r <= cfg_wdata[2:0];
          default:    ;
        endcase
      end else if (ctl.done) begin
        dirty_r <= 1'b0;
      end
    end
  end

  always_comb begin
    zi    = 6'(idx - m);
    t0    = rotr3(win_r[0]) ^ (four ? win_r[2] : '0);
    t1    = t0 ^ rotr1(t0);
    zb    = four ? Z_THREE[zi] : Z_TWO[zi];
    old_k = four ? win_r[3] : win_r[2];
    if (idx < m) begin
      key_out = kw_r[idx[1:0]];
    end else begin
      key_out = ~old_k ^ t1 ^ {{(WORD_W-1){1'b0}}, zb} ^ WORD_W'(3);
    end
  end

  // window: entry 0 holds the newest round key
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      win_r[0] <= key_out;
      win_r[1] <= win_r[0];
      win_r[2] <= win_r[1];
      win_r[3] <= win_r[2];
    end
  end

  assign stat.four  = four;
  assign stat.dirty = dirty_r;

endmodule

### rtl/core/smn64_datapath.sv
module smn64_datapath #(
  parameter int unsigned MAX_ROUNDS = 44,
  parameter int unsigned ADDR_W     = 6
) (
  input  logic                          clk,
  input  smn64_pkg::smn64_dp_ctl_t      ctl,
  input  smn64_pkg::smn64_in_t          in_item,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [smn64_pkg::WORD_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0]             rd_addr,
  output smn64_pkg::smn64_out_t         result
);
  import smn64_pkg::*;

  logic [WORD_W-1:0] rk_mem [MAX_ROUNDS];
  logic [WORD_W-1:0] rk_q_r;
  logic [WORD_W-1:0] x_r;
  logic [WORD_W-1:0] y_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      rk_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rk_q_r <= rk_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r <= in_item.left_word;
      y_r <= in_item.right_word;
    end else if (ctl.apply) begin
      if (ctl.decrypt) begin
        y_r <= x_r ^ round_f(y_r) ^ rk_q_r;
        x_r <= y_r;
      end else begin
        x_r <= y_r ^ round_f(x_r) ^ rk_q_r;
        y_r <= x_r;
      end
    end
  end

  assign result.left_result  = x_r;
  assign result.right_result = y_r;

endmodule
